### src/vrmc_pkg.sv
// shared types, constants and register codes of the vacuum relay median controller
`default_nettype none
package vrmc_pkg;

    // samples in one median window
    localparam int WINDOW = 5;
    localparam int CW = $clog2(WINDOW);
    localparam int MED_IDX = WINDOW / 2;

    // field widths
    localparam int VW = 15;
    localparam int PW = 18;
    localparam int TW = 32;
    localparam int MSW = 16;

    // conversion: v = floor((CONV_OFS - c * CONV_B) / 2^16)
    localparam logic [29:0] CONV_OFS = 30'd986533069;
    localparam logic [13:0] CONV_B = 14'd9733;
    localparam int V_MIN = -16384;
    localparam int V_MAX = 16383;

    // band thresholds as integer ratios
    localparam int THR_ON_M = 5;
    localparam int THR_ON_S = 4;
    localparam int THR_PULSE_M = 200;
    localparam int THR_PULSE_S = 197;
    localparam int THR_OFF_M = 20;
    localparam int THR_OFF_S = 23;

    // configuration register indexes
    localparam int CFG_IW = 3;
    localparam logic [CFG_IW-1:0] REG_SETPOINT = 3'd0;
    localparam logic [CFG_IW-1:0] REG_MIN_ON = 3'd1;
    localparam logic [CFG_IW-1:0] REG_HOLD_WAIT = 3'd2;
    localparam logic [CFG_IW-1:0] REG_OFF_WAIT = 3'd3;

    localparam logic signed [VW-1:0] SETPOINT_RST = -15'sd1024;
    localparam logic [MSW-1:0] MIN_ON_RST = 16'd25;
    localparam logic [MSW-1:0] HOLD_WAIT_RST = 16'd50;
    localparam logic [MSW-1:0] OFF_WAIT_RST = 16'd50;

    typedef logic signed [VW-1:0] vac_t;
    typedef vac_t [WINDOW-1:0] vac_row_t;

    typedef struct packed {
        logic signed [VW-1:0] setpoint;
        logic [MSW-1:0] min_on;
        logic [MSW-1:0] hold_wait;
        logic [MSW-1:0] off_wait;
    } relay_cfg_t;

endpackage
`default_nettype wire

### src/vrmc_conv.sv
// pressure to vacuum conversion with saturation
`default_nettype none
module vrmc_conv (
    input  wire logic [vrmc_pkg::PW-1:0] pressure,
    output vrmc_pkg::vac_t               vacuum
);

    logic [31:0]        prod;
    logic signed [33:0] diff;
    logic signed [17:0] quot;

    assign prod = 32'({14'd0, pressure} * {18'd0, vrmc_pkg::CONV_B});
    assign diff = $signed({4'd0, vrmc_pkg::CONV_OFS}) - $signed({2'd0, prod});
    // arithmetic shift by 16 is the floor division
    assign quot = diff[33:16];

    always_comb
    begin
        if (quot < 18'(vrmc_pkg::V_MIN))
        begin
            vacuum = vrmc_pkg::VW'(vrmc_pkg::V_MIN);
        end
        else if (quot > 18'(vrmc_pkg::V_MAX))
        begin
            vacuum = vrmc_pkg::VW'(vrmc_pkg::V_MAX);
        end
        else
        begin
            vacuum = quot[vrmc_pkg::VW-1:0];
        end
    end

endmodule
`default_nettype wire

### src/vrmc_cell.sv
// one cell of the sample chain, takes its left neighbor on every shift
`default_nettype none
module vrmc_cell (
    input  wire logic           clk,
    input  wire logic           shift,
    input  wire vrmc_pkg::vac_t d,
    output vrmc_pkg::vac_t      q
);

    vrmc_pkg::vac_t value_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            value_reg <= d;
        end
    end

    assign q = value_reg;

endmodule
`default_nettype wire

### src/vrmc_median.sv
// median of the chain by rank counting with index tie break
`default_nettype none
module vrmc_median (
    input  wire vrmc_pkg::vac_row_t row,
    output vrmc_pkg::vac_t          median
);

    logic [vrmc_pkg::CW-1:0] rank [vrmc_pkg::WINDOW];

    always_comb
    begin
        for (int i = 0; i < vrmc_pkg::WINDOW; i++)
        begin
            rank[i] = '0;
            for (int j = 0; j < vrmc_pkg::WINDOW; j++)
            begin
                if (($signed(row[j]) < $signed(row[i])) ||
                    ((row[j] == row[i]) && (j < i)))
                begin
                    rank[i] = rank[i] + 1'b1;
                end
            end
        end
    end

    // ranks are unique, so exactly one element matches
    always_comb
    begin
        median = '0;
        for (int i = 0; i < vrmc_pkg::WINDOW; i++)
        begin
            if (rank[i] == vrmc_pkg::CW'(vrmc_pkg::MED_IDX))
            begin
                median = median | row[i];
            end
        end
    end

endmodule
`default_nettype wire

### src/vrmc_relay.sv
// relay band rule with pulse and hold timing
`default_nettype none
module vrmc_relay (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    en,
    input  wire vrmc_pkg::vac_t          median,
    input  wire logic [vrmc_pkg::TW-1:0] now,
    input  wire vrmc_pkg::relay_cfg_t    cfg,
    output logic                         relay_next
);

    logic                    level_reg, level_next;
    logic                    active_reg, active_next;
    logic [vrmc_pkg::TW-1:0] start_reg, start_next;

    logic signed [24:0] m_w, s_w;
    logic signed [24:0] on_m, on_s, pulse_m, pulse_s, off_m, off_s;
    logic [vrmc_pkg::TW-1:0] elapsed;
    logic [16:0] pulse_lim;

    assign m_w = {{10{median[vrmc_pkg::VW-1]}}, median};
    assign s_w = {{10{cfg.setpoint[vrmc_pkg::VW-1]}}, cfg.setpoint};
    assign on_m = 25'(m_w * vrmc_pkg::THR_ON_M);
    assign on_s = 25'(s_w * vrmc_pkg::THR_ON_S);
    assign pulse_m = 25'(m_w * vrmc_pkg::THR_PULSE_M);
    assign pulse_s = 25'(s_w * vrmc_pkg::THR_PULSE_S);
    assign off_m = 25'(m_w * vrmc_pkg::THR_OFF_M);
    assign off_s = 25'(s_w * vrmc_pkg::THR_OFF_S);

    assign elapsed = now - start_reg;
    assign pulse_lim = {1'b0, cfg.min_on} + {1'b0, cfg.off_wait};

    always_comb
    begin
        level_next = level_reg;
        active_next = active_reg;
        start_next = start_reg;
        if (on_m < on_s)
        begin
            level_next = 1'b1;
            active_next = 1'b0;
        end
        else if (pulse_m < pulse_s)
        begin
            if (!active_reg)
            begin
                start_next = now;
                level_next = 1'b1;
                active_next = 1'b1;
            end
            else if (elapsed > {16'd0, cfg.min_on})
            begin
                level_next = 1'b0;
                if (elapsed > {15'd0, pulse_lim})
                begin
                    active_next = 1'b0;
                end
            end
        end
        else if (off_m > off_s)
        begin
            level_next = 1'b0;
            active_next = 1'b0;
        end
        else
        begin
            // dead band: off, then hold for a wait
            if (!active_reg)
            begin
                start_next = now;
                level_next = 1'b0;
                active_next = 1'b1;
            end
            else if (elapsed > {16'd0, cfg.hold_wait})
            begin
                active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= 1'b0;
            active_reg <= 1'b0;
            start_reg <= '0;
        end
        else if (en)
        begin
            level_reg <= level_next;
            active_reg <= active_next;
            start_reg <= start_next;
        end
    end

    assign relay_next = level_next;

endmodule
`default_nettype wire

### src/vacuum_relay_median_controller_unit.sv
// top level of the vacuum relay median controller
//
// sample channel: pressure_centi_hpa and time_ms, taken when sample_valid is high
// and sample_stall is low. each sample is converted to vacuum psi (1/1024 steps)
// and shifted into a chain of five cells. every fifth sample closes a window:
// the median of the chain is registered, the relay rule runs on it and one
// result (median_vacuum_psi, relay_on) goes out on the result channel, taken
// when result_valid is high and result_stall is low. other samples give no result.
// throughput is one sample per cycle while sample_stall is low; the sample that
// closes a window passes the input register, the chain shift, the median register
// and the relay/output register, where result_valid rises.
// a result waiting under result_stall does not block samples until the median
// register and the chain each hold a further full window behind it and the input
// register is full too; then sample_stall rises.
// configuration: cfg_valid with cfg_index and cfg_data, cfg_ready always high;
// write only while idle.
// reset clears all handshake state, the sample count, the relay (off) and its
// timer, and loads register defaults; the chain needs no clearing.
`default_nettype none
module vacuum_relay_median_controller_unit (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        sample_valid,
    output logic                             sample_stall,
    input  wire logic [vrmc_pkg::PW-1:0]     pressure_centi_hpa,
    input  wire logic [vrmc_pkg::TW-1:0]     time_ms,
    output logic                             result_valid,
    input  wire logic                        result_stall,
    output logic signed [vrmc_pkg::VW-1:0]   median_vacuum_psi,
    output logic                             relay_on,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [vrmc_pkg::CFG_IW-1:0] cfg_index,
    input  wire logic [vrmc_pkg::MSW-1:0]    cfg_data
);

    vrmc_pkg::relay_cfg_t cfg_reg;

    logic                    s1_valid_reg;
    vrmc_pkg::vac_t          s1_vac_reg;
    logic [vrmc_pkg::TW-1:0] s1_time_reg;

    logic                    full_valid_reg;
    logic [vrmc_pkg::TW-1:0] full_time_reg;
    logic [vrmc_pkg::CW-1:0] count_reg;

    logic                    med_valid_reg;
    vrmc_pkg::vac_t          med_reg;
    logic [vrmc_pkg::TW-1:0] med_time_reg;

    logic                    out_valid_reg;
    vrmc_pkg::vac_t          out_median_reg;
    logic                    out_relay_reg;

    logic out_free, med_go, med_free, full_go, full_free, cells_shift, s1_free, accept;
    logic relay_next;
    vrmc_pkg::vac_t     conv_vac, median;
    vrmc_pkg::vac_row_t row;

    // backpressure chain from the result side to the sample side
    assign out_free = !out_valid_reg || !result_stall;
    assign med_go = med_valid_reg && out_free;
    assign med_free = !med_valid_reg || out_free;
    assign full_go = full_valid_reg && med_free;
    assign full_free = !full_valid_reg || med_free;
    assign cells_shift = s1_valid_reg && full_free;
    assign s1_free = !s1_valid_reg || cells_shift;
    assign accept = sample_valid && s1_free;
    assign sample_stall = !s1_free;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.setpoint <= vrmc_pkg::SETPOINT_RST;
            cfg_reg.min_on <= vrmc_pkg::MIN_ON_RST;
            cfg_reg.hold_wait <= vrmc_pkg::HOLD_WAIT_RST;
            cfg_reg.off_wait <= vrmc_pkg::OFF_WAIT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                vrmc_pkg::REG_SETPOINT:  cfg_reg.setpoint <= cfg_data[vrmc_pkg::VW-1:0];
                vrmc_pkg::REG_MIN_ON:    cfg_reg.min_on <= cfg_data;
                vrmc_pkg::REG_HOLD_WAIT: cfg_reg.hold_wait <= cfg_data;
                vrmc_pkg::REG_OFF_WAIT:  cfg_reg.off_wait <= cfg_data;
                default: ;
            endcase
        end
    end

    vrmc_conv u_conv (
        .pressure (pressure_centi_hpa),
        .vacuum   (conv_vac)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept || (s1_valid_reg && !cells_shift);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_vac_reg <= conv_vac;
            s1_time_reg <= time_ms;
        end
    end

    for (genvar i = 0; i < vrmc_pkg::WINDOW; i++)
    begin : g_cell
        vrmc_cell u_cell (
            .clk   (clk),
            .shift (cells_shift),
            .d     ((i == 0) ? s1_vac_reg : row[(i == 0) ? 0 : i - 1]),
            .q     (row[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            full_valid_reg <= 1'b0;
        end
        else
        begin
            if (cells_shift)
            begin
                if (count_reg == vrmc_pkg::CW'(vrmc_pkg::WINDOW - 1))
                begin
                    count_reg <= '0;
                end
                else
                begin
                    count_reg <= count_reg + 1'b1;
                end
            end
            if (cells_shift && (count_reg == vrmc_pkg::CW'(vrmc_pkg::WINDOW - 1)))
            begin
                full_valid_reg <= 1'b1;
            end
            else if (full_go)
            begin
                full_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cells_shift && (count_reg == vrmc_pkg::CW'(vrmc_pkg::WINDOW - 1)))
        begin
            full_time_reg <= s1_time_reg;
        end
    end

    vrmc_median u_median (
        .row    (row),
        .median (median)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            med_valid_reg <= 1'b0;
        end
        else if (full_go)
        begin
            med_valid_reg <= 1'b1;
        end
        else if (med_go)
        begin
            med_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (full_go)
        begin
            med_reg <= median;
            med_time_reg <= full_time_reg;
        end
    end

    vrmc_relay u_relay (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (med_go),
        .median     (med_reg),
        .now        (med_time_reg),
        .cfg        (cfg_reg),
        .relay_next (relay_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (med_go)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (med_go)
        begin
            out_median_reg <= med_reg;
            out_relay_reg <= relay_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign median_vacuum_psi = out_median_reg;
    assign relay_on = out_relay_reg;

`ifndef ASSERT_OFF
    a_chain_holds_window: assert property (@(posedge clk) disable iff (!rst_n)
        (full_valid_reg && !med_free) |-> !cells_shift)
        else $error("chain shifted over an untaken window");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= vrmc_pkg::CW'(vrmc_pkg::WINDOW - 1))
        else $error("sample count out of range");

    a_empty_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> !sample_stall)
        else $error("request stalled with empty input stage");

    a_median_to_result: assert property (@(posedge clk) disable iff (!rst_n)
        med_go |=> (result_valid && (median_vacuum_psi == $past(med_reg))))
        else $error("median did not reach the result register");
`endif

endmodule
`default_nettype wire
